// ===== hw/rtl/cpu_6502_subset_step_defines.svh =====
// ----------------------------------------------------------------------------
// cpu_6502_subset_step_defines
// assertion macros used by the cpu subset step module
// ----------------------------------------------------------------------------
`ifndef CPU_6502_SUBSET_STEP_DEFINES_SVH
`define CPU_6502_SUBSET_STEP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CPU6502_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CPU6502_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cpu6502_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu6502_pkg
// types and constants of the cpu subset step engine
// ----------------------------------------------------------------------------
package cpu6502_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_VEC_LO,
        ST_VEC_HI,
        ST_VEC_DONE,
        ST_FETCH_OP,
        ST_FETCH_ARG,
        ST_EXEC,
        ST_POP,
        ST_DONE
    } state_t;

    localparam logic [7:0] OP_PHP = 8'h08;
    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_PLP = 8'h28;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PLA = 8'h68;
    localparam logic [7:0] OP_ADC = 8'h69;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_LDA = 8'hA9;
    localparam logic [7:0] OP_BCS = 8'hB0;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_CLD = 8'hD8;
    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_SED = 8'hF8;

    localparam logic [15:0] VEC_LO_ADDR = 16'hFFFC;
    localparam logic [15:0] VEC_HI_ADDR = 16'hFFFD;
    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [7:0]  SP_RESET    = 8'hFF;

    localparam int FLAG_C = 0;
    localparam int FLAG_D = 3;

endpackage

// ===== hw/rtl/cpu6502_ram.sv =====
// ----------------------------------------------------------------------------
// cpu6502_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module cpu6502_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hw/rtl/cpu_6502_subset_step.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_subset_step: 6502 subset with internal 64k x 8 memory, one command per transaction
// accept to result: write, done; read, read wait, done; vec lo, vec hi, vec done, done; step:
// fetch op, fetch arg, exec, pop for pla and plp, done; one command at a time, the next taken
// in idle after the result registers; the single-port memory serves opcode, operand, stack in
// turn; no clearing pass; reset: pc 0, sp ff, a x flags 0, memory undefined until written
// ----------------------------------------------------------------------------
`include "cpu_6502_subset_step_defines.svh"

module cpu_6502_subset_step #(
    parameter int ADDR_BITS = 16,
    localparam int IN_BITS  = ADDR_BITS + 8,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 3 + 8 + ADDR_BITS + 32,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // command channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // mem_addr, mem_data
    input  logic [1:0]       s_tuser,   // cmd
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // cycles, read_byte, pc_out, acc_out, x_out,
                                        // sp_out, status_flags
    output logic [0:0]       m_tuser    // status
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    cpu6502_pkg::state_t state_reg, state_next;

    // latched command transaction
    cpu6502_pkg::cmd_t      cmd_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [7:0]             data_reg;

    // architectural state outside memory
    logic [ADDR_BITS-1:0]   pc_reg;
    logic [7:0]             a_reg;
    logic [7:0]             x_reg;
    logic [7:0]             sp_reg;
    logic [7:0]             p_reg;

    // working registers of the instruction sequence
    logic [7:0]             op_reg;
    logic [7:0]             lo_reg;
    logic                   res_status_reg;
    logic [2:0]             res_cycles_reg;
    logic [7:0]             res_rd_reg;

    // output register, parts the result side from the command side
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [0:0]             m_tuser_reg;

    // memory port
    logic                   ram_en;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic                   s_accept;
    logic                   out_free;
    logic [ADDR_BITS-1:0]   pc_inc1;
    logic [ADDR_BITS-1:0]   pc_inc2;
    logic [7:0]             sp_inc;
    logic [7:0]             sp_dec;
    logic [ADDR_BITS-1:0]   br_off;
    logic [ADDR_BITS-1:0]   br_target;
    logic                   br_cross;
    logic [8:0]             adc_sum;
    logic                   exec_err;
    logic [2:0]             exec_cycles;
    logic [ADDR_BITS-1:0]   exec_pc;
    logic                   is_push;
    logic                   is_pop;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == cpu6502_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pc_inc1 = pc_reg + ADDR_BITS'(1);
    assign pc_inc2 = pc_reg + ADDR_BITS'(2);
    assign sp_inc  = sp_reg + 8'd1;
    assign sp_dec  = sp_reg - 8'd1;

    // during exec the memory read data is the operand byte
    assign br_off    = {{(ADDR_BITS-8){ram_rdata[7]}}, ram_rdata};
    assign br_target = pc_inc2 + br_off;
    assign br_cross  = (br_target[ADDR_BITS-1:8] != pc_inc2[ADDR_BITS-1:8]);
    assign adc_sum   = 9'(a_reg) + 9'(ram_rdata) + 9'(p_reg[cpu6502_pkg::FLAG_C]);

    // opcode decode: cycle count and next pc, or error for unknown opcode and decimal adc
    always_comb begin
        exec_err    = 1'b0;
        exec_cycles = 3'd2;
        exec_pc     = pc_inc1;
        unique case (op_reg) inside
            cpu6502_pkg::OP_PHP, cpu6502_pkg::OP_CLC, cpu6502_pkg::OP_SEC,
            cpu6502_pkg::OP_TXS, cpu6502_pkg::OP_TSX,
            cpu6502_pkg::OP_CLD, cpu6502_pkg::OP_NOP, cpu6502_pkg::OP_SED: begin
                exec_cycles = 3'd2;
            end
            cpu6502_pkg::OP_LDA: begin
                exec_cycles = 3'd2;
                exec_pc     = pc_inc2;
            end
            cpu6502_pkg::OP_PHA: begin
                exec_cycles = 3'd3;
            end
            cpu6502_pkg::OP_PLP, cpu6502_pkg::OP_PLA: begin
                exec_cycles = 3'd4;
            end
            cpu6502_pkg::OP_ADC: begin
                exec_err    = p_reg[cpu6502_pkg::FLAG_D];
                exec_cycles = p_reg[cpu6502_pkg::FLAG_D] ? 3'd0 : 3'd2;
                exec_pc     = pc_inc2;
            end
            cpu6502_pkg::OP_BCS: begin
                if (!p_reg[cpu6502_pkg::FLAG_C]) begin
                    exec_cycles = 3'd2;
                    exec_pc     = pc_inc2;
                end else begin
                    exec_cycles = br_cross ? 3'd4 : 3'd3;
                    exec_pc     = br_target;
                end
            end
            default: begin
                exec_err    = 1'b1;
                exec_cycles = 3'd0;
            end
        endcase
    end

    assign is_push = (op_reg == cpu6502_pkg::OP_PHP) || (op_reg == cpu6502_pkg::OP_PHA);
    assign is_pop  = (op_reg == cpu6502_pkg::OP_PLP) || (op_reg == cpu6502_pkg::OP_PLA);

    // ------------------------------------------------------------------
    // sequencer: next state and memory port
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = addr_reg;
        ram_wdata  = data_reg;
        unique case (state_reg)
            cpu6502_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (cpu6502_pkg::cmd_t'(s_tuser))
                        cpu6502_pkg::CMD_WRITE: state_next = cpu6502_pkg::ST_WRITE;
                        cpu6502_pkg::CMD_READ:  state_next = cpu6502_pkg::ST_READ;
                        cpu6502_pkg::CMD_RESET: state_next = cpu6502_pkg::ST_VEC_LO;
                        cpu6502_pkg::CMD_STEP:  state_next = cpu6502_pkg::ST_FETCH_OP;
                        default:                state_next = cpu6502_pkg::ST_IDLE;
                    endcase
                end
            end
            cpu6502_pkg::ST_WRITE: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                state_next = cpu6502_pkg::ST_DONE;
            end
            cpu6502_pkg::ST_READ: begin
                ram_en     = 1'b1;
                state_next = cpu6502_pkg::ST_READ_WAIT;
            end
            cpu6502_pkg::ST_READ_WAIT: begin
                state_next = cpu6502_pkg::ST_DONE;
            end
            cpu6502_pkg::ST_VEC_LO: begin
                ram_en     = 1'b1;
                ram_addr   = ADDR_BITS'(cpu6502_pkg::VEC_LO_ADDR);
                state_next = cpu6502_pkg::ST_VEC_HI;
            end
            cpu6502_pkg::ST_VEC_HI: begin
                ram_en     = 1'b1;
                ram_addr   = ADDR_BITS'(cpu6502_pkg::VEC_HI_ADDR);
                state_next = cpu6502_pkg::ST_VEC_DONE;
            end
            cpu6502_pkg::ST_VEC_DONE: begin
                state_next = cpu6502_pkg::ST_DONE;
            end
            cpu6502_pkg::ST_FETCH_OP: begin
                ram_en     = 1'b1;
                ram_addr   = pc_reg;
                state_next = cpu6502_pkg::ST_FETCH_ARG;
            end
            cpu6502_pkg::ST_FETCH_ARG: begin
                ram_en     = 1'b1;
                ram_addr   = pc_inc1;
                state_next = cpu6502_pkg::ST_EXEC;
            end
            cpu6502_pkg::ST_EXEC: begin
                state_next = cpu6502_pkg::ST_DONE;
                if (is_push) begin
                    // push stores at page one then sp moves down
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_addr  = ADDR_BITS'({cpu6502_pkg::STACK_PAGE, sp_reg});
                    ram_wdata = (op_reg == cpu6502_pkg::OP_PHP) ? p_reg : a_reg;
                end else if (is_pop) begin
                    // pop moves sp up then loads
                    ram_en     = 1'b1;
                    ram_addr   = ADDR_BITS'({cpu6502_pkg::STACK_PAGE, sp_inc});
                    state_next = cpu6502_pkg::ST_POP;
                end
            end
            cpu6502_pkg::ST_POP: begin
                state_next = cpu6502_pkg::ST_DONE;
            end
            cpu6502_pkg::ST_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    state_next = cpu6502_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpu6502_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and architectural registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cpu6502_pkg::ST_IDLE;
            pc_reg       <= '0;
            a_reg        <= '0;
            x_reg        <= '0;
            sp_reg       <= cpu6502_pkg::SP_RESET;
            p_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // a new result may replace the one leaving in the same cycle
            if (state_reg == cpu6502_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                cpu6502_pkg::ST_VEC_DONE: begin
                    pc_reg <= ADDR_BITS'({ram_rdata, lo_reg});
                end
                cpu6502_pkg::ST_EXEC: begin
                    // errors leave every architectural register untouched
                    if (!exec_err) begin
                        pc_reg <= exec_pc;
                        unique case (op_reg) inside
                            cpu6502_pkg::OP_PHP, cpu6502_pkg::OP_PHA: begin
                                sp_reg <= sp_dec;
                            end
                            cpu6502_pkg::OP_PLP, cpu6502_pkg::OP_PLA: begin
                                sp_reg <= sp_inc;
                            end
                            cpu6502_pkg::OP_CLC: p_reg[cpu6502_pkg::FLAG_C] <= 1'b0;
                            cpu6502_pkg::OP_SEC: p_reg[cpu6502_pkg::FLAG_C] <= 1'b1;
                            cpu6502_pkg::OP_CLD: p_reg[cpu6502_pkg::FLAG_D] <= 1'b0;
                            cpu6502_pkg::OP_SED: p_reg[cpu6502_pkg::FLAG_D] <= 1'b1;
                            cpu6502_pkg::OP_ADC: begin
                                p_reg[cpu6502_pkg::FLAG_C] <= adc_sum[8];
                                a_reg  <= adc_sum[7:0];
                            end
                            cpu6502_pkg::OP_LDA: begin
                                a_reg  <= ram_rdata;
                            end
                            cpu6502_pkg::OP_TXS: sp_reg <= x_reg;
                            cpu6502_pkg::OP_TSX: x_reg  <= sp_reg;
                            default: ;
                        endcase
                    end
                end
                cpu6502_pkg::ST_POP: begin
                    if (op_reg == cpu6502_pkg::OP_PLP) begin
                        p_reg <= ram_rdata;
                    end else begin
                        a_reg <= ram_rdata;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            cpu6502_pkg::ST_IDLE: begin
                if (s_accept) begin
                    cmd_reg        <= cpu6502_pkg::cmd_t'(s_tuser);
                    addr_reg       <= s_tdata[ADDR_BITS-1:0];
                    data_reg       <= s_tdata[ADDR_BITS+7:ADDR_BITS];
                    res_status_reg <= 1'b0;
                    res_cycles_reg <= 3'd0;
                    res_rd_reg     <= 8'd0;
                end
            end
            cpu6502_pkg::ST_READ_WAIT: begin
                if (cmd_reg == cpu6502_pkg::CMD_READ) begin
                    res_rd_reg <= ram_rdata;
                end
            end
            cpu6502_pkg::ST_VEC_HI: begin
                lo_reg <= ram_rdata;
            end
            cpu6502_pkg::ST_FETCH_ARG: begin
                op_reg <= ram_rdata;
            end
            cpu6502_pkg::ST_EXEC: begin
                res_status_reg <= exec_err;
                res_cycles_reg <= exec_cycles;
            end
            cpu6502_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= OUT_W'({p_reg, sp_reg, x_reg, a_reg, pc_reg,
                                           res_rd_reg, res_cycles_reg});
                    m_tuser_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // main memory
    // ------------------------------------------------------------------
    cpu6502_ram #(
        .WIDTH (8),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // memory is written only by the write command and by pushes
    `CPU6502_ASSERT_IMP(a_ram_we_state, aclk, aresetn, ram_we, state_reg == cpu6502_pkg::ST_WRITE || state_reg == cpu6502_pkg::ST_EXEC, "memory write outside write or exec")
    // an accepted command always starts a sequence
    `CPU6502_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_accept, state_reg != cpu6502_pkg::ST_IDLE, "accepted command did not start")
    // error results report zero cycles
    `CPU6502_ASSERT_IMP(a_err_zero_cycles, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0], m_tdata_reg[2:0] == 3'd0, "error result with nonzero cycles")
    // stack pointer moves only while an instruction executes
    `CPU6502_ASSERT_NXT(a_sp_only_exec, aclk, aresetn, state_reg != cpu6502_pkg::ST_EXEC, $stable(sp_reg), "stack pointer changed outside exec")

endmodule
